// ===== sv/avsd_pkg.sv =====
package avsd_pkg;

   localparam int SAMPLE_W       = 10;
   localparam int FS_W           = 14;
   localparam int SEL_W          = 8;
   localparam int SEG_W          = 8;
   localparam int DIGIT_W        = 4;
   localparam int MV_W           = 14;
   localparam int ADC_BITS_DEF   = 10;
   localparam int FIFO_DEPTH_DEF = 4;

   localparam logic [FS_W-1:0]  FS_RESET   = 14'd5000;
   localparam logic [MV_W-1:0]  MV_MAX     = 14'd9999;
   localparam logic [SEG_W-1:0] DP_CLEAR   = 8'hfe;
   localparam logic [SEG_W-1:0] SEG_BLANK  = 8'hff;
   localparam logic [SEL_W-1:0] SEL_FIRST  = 8'h80;

   typedef struct packed {
      logic [DIGIT_W-1:0] thousands;
      logic [DIGIT_W-1:0] hundreds;
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] ones;
   } digits_type;

   typedef struct packed {
      logic [MV_W-1:0]    rem;
      logic [DIGIT_W-1:0] digit;
   } split_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_status_type;

   // One decimal digit: nine parallel compares against multiples of unit.
   // value must stay below 10*unit.
   function automatic split_type split_digit(input logic [MV_W-1:0] value,
                                             input logic [MV_W-1:0] unit);
      split_type       res;
      logic [MV_W-1:0] mult;
      res.digit = '0;
      res.rem   = value;
      for (int k = 1; k < 10; k++) begin
         mult = MV_W'(k) * unit;
         if (value >= mult) begin
            res.digit = DIGIT_W'(k);
            res.rem   = value - mult;
         end
      end
      return res;
   endfunction

   // Active-low segment patterns, bit0 is the decimal point.
   function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 8'h03;
         4'd1:    s = 8'h9f;
         4'd2:    s = 8'h25;
         4'd3:    s = 8'h0d;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h49;
         4'd6:    s = 8'h41;
         4'd7:    s = 8'h1f;
         4'd8:    s = 8'h01;
         4'd9:    s = 8'h09;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

endpackage

// ===== sv/avsd_front.sv =====
module avsd_front
   import avsd_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [FS_W-1:0]     full_scale,
   output logic                out_valid,
   output digits_type          out_digits
);

   localparam int EXT_W  = (ADC_BITS > SAMPLE_W) ? ADC_BITS : SAMPLE_W;
   localparam int PROD_W = EXT_W + FS_W;
   localparam int SUM_W  = PROD_W + 1;

   localparam logic [EXT_W-1:0] SAMPLE_MASK = (EXT_W'(1) << ADC_BITS) - EXT_W'(1);
   localparam logic [SUM_W-1:0] ROUND_HALF  = SUM_W'(1) << (ADC_BITS - 1);

   logic [4:0] v_ff, v_in;

   logic [EXT_W-1:0]   masked;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [SUM_W-1:0]   scaled;
   logic [MV_W-1:0]    mv_ff, mv_in;
   split_type          sp3, sp4, sp5;
   logic [DIGIT_W-1:0] thou3_ff, thou4_ff, thou5_ff;
   logic [DIGIT_W-1:0] hund4_ff, hund5_ff;
   logic [DIGIT_W-1:0] tens5_ff, ones5_ff;
   logic [9:0]         rem3_ff;
   logic [6:0]         rem4_ff;

   always_comb begin
      v_in    = {v_ff[3:0], in_valid};
      masked  = EXT_W'(sample) & SAMPLE_MASK;
      prod_in = PROD_W'(masked) * PROD_W'(full_scale);
      scaled  = (SUM_W'(prod_ff) + ROUND_HALF) >> ADC_BITS;
      if (scaled > SUM_W'(MV_MAX)) begin
         mv_in = MV_MAX;
      end else begin
         mv_in = scaled[MV_W-1:0];
      end
      sp3 = split_digit(mv_ff, MV_W'(1000));
      sp4 = split_digit(MV_W'(rem3_ff), MV_W'(100));
      sp5 = split_digit(MV_W'(rem4_ff), MV_W'(10));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mv_ff    <= mv_in;
      thou3_ff <= sp3.digit;
      rem3_ff  <= sp3.rem[9:0];
      thou4_ff <= thou3_ff;
      hund4_ff <= sp4.digit;
      rem4_ff  <= sp4.rem[6:0];
      thou5_ff <= thou4_ff;
      hund5_ff <= hund4_ff;
      tens5_ff <= sp5.digit;
      ones5_ff <= sp5.rem[DIGIT_W-1:0];
   end

   assign out_valid            = v_ff[4];
   assign out_digits.thousands = thou5_ff;
   assign out_digits.hundreds  = hund5_ff;
   assign out_digits.tens      = tens5_ff;
   assign out_digits.ones      = ones5_ff;

endmodule

// ===== sv/avsd_fifo.sv =====
module avsd_fifo
   import avsd_pkg::*;
#(
   parameter int DEPTH = FIFO_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  digits_type      wr_data,
   input  logic            pop,
   output digits_type      rd_data,
   output fifo_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   digits_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

endmodule

// ===== sv/avsd_back.sv =====
module avsd_back
   import avsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  fifo_status_type  status,
   input  digits_type       rd_data,
   output logic             pop,
   output logic             rsp_valid,
   output logic [SEL_W-1:0] rsp_digit_select,
   output logic [SEG_W-1:0] rsp_segments,
   output logic             rsp_last
);

   localparam logic [1:0] FRAME_THOU = 2'd0;
   localparam logic [1:0] FRAME_HUND = 2'd1;
   localparam logic [1:0] FRAME_TENS = 2'd2;
   localparam logic [1:0] FRAME_ONES = 2'd3;

   logic       active_ff, active_in;
   logic [1:0] frame_ff, frame_in;
   digits_type digits_ff, digits_in;

   logic [DIGIT_W-1:0] cur_digit;
   logic [SEG_W-1:0]   seg;

   always_comb begin
      pop       = !status.empty && (!active_ff || frame_ff == FRAME_ONES);
      active_in = active_ff;
      frame_in  = frame_ff;
      digits_in = digits_ff;
      if (pop) begin
         active_in = 1'b1;
         frame_in  = FRAME_THOU;
         digits_in = rd_data;
      end else if (active_ff) begin
         if (frame_ff == FRAME_ONES) begin
            active_in = 1'b0;
         end else begin
            frame_in = frame_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         frame_ff  <= FRAME_THOU;
      end else begin
         active_ff <= active_in;
         frame_ff  <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
   end

   always_comb begin
      case (frame_ff)
         FRAME_THOU: cur_digit = digits_ff.thousands;
         FRAME_HUND: cur_digit = digits_ff.hundreds;
         FRAME_TENS: cur_digit = digits_ff.tens;
         FRAME_ONES: cur_digit = digits_ff.ones;
         default:    cur_digit = digits_ff.ones;
      endcase
      seg = seg_of(cur_digit);
      if (frame_ff == FRAME_THOU) begin
         seg = seg & DP_CLEAR;
      end
   end

   assign rsp_valid        = active_ff;
   assign rsp_digit_select = SEL_FIRST >> frame_ff;
   assign rsp_segments     = seg;
   assign rsp_last         = active_ff && (frame_ff == FRAME_ONES);

endmodule

// ===== sv/adc_voltmeter_seven_segment_frames.sv =====
// ADC voltmeter to seven-segment display frames.
// Request: pulse start with req_sample while busy is low; the transaction is
//   taken at that edge. busy rises only when the digit queue has no room left
//   for another sample (FIFO_DEPTH samples in flight or waiting).
// Response: each sample gives four frames, thousands digit first, each shown
//   for one cycle with rsp_valid high: one-hot rsp_digit_select (0x80..0x10),
//   active-low rsp_segments (decimal point lit on the first frame) and
//   rsp_last on the fourth. The receiver cannot stall the frames.
// Path: an accepted sample goes through the front pipeline into the digit
//   queue, where it waits until the sequencer takes it and shows its frames.
// Throughput: the frame sequencer drives one frame a cycle, four per sample,
//   and sets the sustained sample rate. Samples may arrive back to back while
//   busy is low; the five-stage front pipeline (multiply, round/saturate, one
//   digit a stage) and the queue absorb bursts of up to FIFO_DEPTH samples.
// Config: csr_we writes full-scale millivolts from csr_wdata; write only
//   when no transaction is in flight.
// Reset: synchronous, clears the pipeline valid flags, queue pointers, credit
//   count and sequencer, and loads full scale with 5000 mV.
module adc_voltmeter_seven_segment_frames
   import avsd_pkg::*;
#(
   parameter int ADC_BITS   = ADC_BITS_DEF,
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                csr_we,
   input  logic [FS_W-1:0]     csr_wdata,
   output logic                rsp_valid,
   output logic [SEL_W-1:0]    rsp_digit_select,
   output logic [SEG_W-1:0]    rsp_segments,
   output logic                rsp_last
);

   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic [FS_W-1:0]  fs_ff, fs_in;
   // samples accepted but not yet handed to the sequencer
   logic [CNT_W-1:0] credit_ff, credit_in;

   logic            accept;
   logic            front_valid;
   digits_type      front_digits;
   digits_type      q_data;
   fifo_status_type q_status;
   logic            q_pop;

   assign accept = start && !busy;
   assign busy   = (credit_ff == CNT_W'(FIFO_DEPTH));

   always_comb begin
      fs_in     = csr_we ? csr_wdata : fs_ff;
      credit_in = credit_ff;
      if (accept && !q_pop) begin
         credit_in = credit_ff + CNT_W'(1);
      end else if (q_pop && !accept) begin
         credit_in = credit_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff     <= FS_RESET;
         credit_ff <= '0;
      end else begin
         fs_ff     <= fs_in;
         credit_ff <= credit_in;
      end
   end

   avsd_front #(
      .ADC_BITS (ADC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .sample     (req_sample),
      .full_scale (fs_ff),
      .out_valid  (front_valid),
      .out_digits (front_digits)
   );

   avsd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (front_valid),
      .wr_data (front_digits),
      .pop     (q_pop),
      .rd_data (q_data),
      .status  (q_status)
   );

   avsd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .status           (q_status),
      .rd_data          (q_data),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments),
      .rsp_last         (rsp_last)
   );

   // credit never passes the queue depth
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CNT_W'(FIFO_DEPTH))
      else $error("credit count above queue depth");

   // an accepted transaction holds a credit until its digits are popped
   a_credit_taken: assert property (@(posedge clock) disable iff (reset)
      accept |=> credit_ff != '0)
      else $error("accepted transaction left no credit");

   // frames of one transaction come in consecutive cycles
   a_frames_contig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("gap inside a frame group");

   // after the last frame, either idle or a new group starting at the first digit
   a_new_group: assert property (@(posedge clock) disable iff (reset)
      rsp_last |=> !rsp_valid || rsp_digit_select == SEL_FIRST)
      else $error("frame group did not restart at first digit");

   // queue never pushed while full unless popped in the same cycle
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      front_valid |-> !q_status.full || q_pop)
      else $error("digit queue overflow");

endmodule

// ===== verif/voltmeter_frame_checker.sv =====
module voltmeter_frame_checker
   import avsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                csr_we,
   input  logic [FS_W-1:0]     csr_wdata,
   input  logic                rsp_valid,
   input  logic [SEL_W-1:0]    rsp_digit_select,
   input  logic [SEG_W-1:0]    rsp_segments,
   input  logic                rsp_last,
   input  logic                run_done,
   output int                  frames_pending,
   output int                  error_count
);

   localparam int ADC_BITS = ADC_BITS_DEF;

   // active-low glyphs for 0..9, bit0 = decimal point
   localparam logic [SEG_W-1:0] GLYPH [10] = '{
      8'h03, 8'h9f, 8'h25, 8'h0d, 8'h99, 8'h49, 8'h41, 8'h1f, 8'h01, 8'h09
   };

   typedef struct packed {
      logic [SEL_W-1:0] select;
      logic [SEG_W-1:0] segs;
      logic             last;
   } frame_type;

   logic [FS_W-1:0] full_scale_mv;
   frame_type       display_frames [$];
   bit              leftovers_counted;

   // scaled reading, rounded half up, clamped at 9.999 V
   function automatic logic [MV_W-1:0] sample_millivolts(input logic [SAMPLE_W-1:0] s,
                                                         input logic [FS_W-1:0]     fs);
      logic [SAMPLE_W-1:0] mask;
      logic [31:0]         product;
      logic [31:0]         mv;
      mask    = SAMPLE_W'((64'd1 << ADC_BITS) - 1);
      product = 32'(s & mask) * 32'(fs);
      mv      = (product + (32'd1 << (ADC_BITS - 1))) >> ADC_BITS;
      if (mv > 32'(MV_MAX)) begin
         mv = 32'(MV_MAX);
      end
      return MV_W'(mv);
   endfunction

   task automatic queue_display_frames(input logic [SAMPLE_W-1:0] s);
      int unsigned value;
      int unsigned digit [4];
      frame_type   f;
      value    = 32'(sample_millivolts(s, full_scale_mv));
      digit[0] = value / 1000;
      digit[1] = (value / 100) % 10;
      digit[2] = (value / 10) % 10;
      digit[3] = value % 10;
      for (int k = 0; k < 4; k++) begin
         f.select = SEL_FIRST >> k;
         f.segs   = GLYPH[digit[k]];
         if (k == 0) begin
            f.segs = f.segs & DP_CLEAR;
         end
         f.last = (k == 3);
         display_frames.push_back(f);
      end
   endtask

   always @(posedge clock) begin : watch
      int        errs;
      frame_type want;
      errs = 0;
      if (reset) begin
         full_scale_mv     <= FS_RESET;
         leftovers_counted <= 1'b0;
         display_frames.delete();
      end else begin
         if (csr_we) begin
            full_scale_mv <= csr_wdata;
         end
         if (start && !busy) begin
            queue_display_frames(req_sample);
         end
         if (rsp_valid) begin
            if (display_frames.size() == 0) begin
               $display("%0t: unexpected frame sel=%h seg=%h last=%b",
                        $time, rsp_digit_select, rsp_segments, rsp_last);
               errs++;
            end else begin
               want = display_frames.pop_front();
               if (rsp_digit_select !== want.select) begin
                  $display("%0t: digit_select expected %h actual %h",
                           $time, want.select, rsp_digit_select);
                  errs++;
               end
               if (rsp_segments !== want.segs) begin
                  $display("%0t: segments expected %h actual %h",
                           $time, want.segs, rsp_segments);
                  errs++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
                  errs++;
               end
            end
         end
         if (run_done && !leftovers_counted) begin
            leftovers_counted <= 1'b1;
            if (display_frames.size() != 0) begin
               $display("%0t: %0d frames expected but never shown",
                        $time, display_frames.size());
               errs += display_frames.size();
            end
         end
      end
      error_count    <= error_count + errs;
      frames_pending <= display_frames.size();
   end

endmodule

// ===== verif/tb_top.sv =====
// Top of the voltmeter display testbench. Generates clock, reset and all
// stimulus; the checker beside the DUT predicts the four frames of each
// sample and flags every difference. Verdict is printed here.
module tb_top;
   import avsd_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic                csr_we = 1'b0;
   logic [FS_W-1:0]     csr_wdata = '0;
   logic                rsp_valid;
   logic [SEL_W-1:0]    rsp_digit_select;
   logic [SEG_W-1:0]    rsp_segments;
   logic                rsp_last;
   logic                run_done = 1'b0;
   int                  frames_pending;
   int                  error_count;

   // chance (percent) of an idle cycle before each transaction
   int                  idle_pct = 0;

   always #2 clock = ~clock;

   adc_voltmeter_seven_segment_frames u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample       (req_sample),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments),
      .rsp_last         (rsp_last)
   );

   voltmeter_frame_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample       (req_sample),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments),
      .rsp_last         (rsp_last),
      .run_done         (run_done),
      .frames_pending   (frames_pending),
      .error_count      (error_count)
   );

   // Watchdog. Fails the run as hung if it has not finished when the delay
   // below runs out.
   initial begin
      #800000;
      $display("Verification failed");
      $finish;
   end

   // Called and returns right after a falling edge. Optional idle cycles
   // first (sample bus carries junk then), then holds start until the
   // transaction is taken. start is left high on return so back-to-back
   // transactions see no gap.
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      while ($urandom_range(0, 99) < idle_pct) begin
         start      = 1'b0;
         req_sample = SAMPLE_W'($urandom);
         @(negedge clock);
      end
      start      = 1'b1;
      req_sample = s;
      do begin
         @(posedge clock);
      end while (busy);
      @(negedge clock);
   endtask

   // Stop sending and wait for every predicted frame, then let the pipeline
   // settle before anything else happens.
   task automatic drain_frames();
      int waited;
      waited = 0;
      start  = 1'b0;
      while (frames_pending != 0 && waited < 400) begin
         @(negedge clock);
         waited++;
      end
      repeat (12) @(negedge clock);
   endtask

   // Full-scale register: single-cycle write, only called with the DUT idle.
   task automatic write_full_scale(input logic [FS_W-1:0] fs);
      csr_we    = 1'b1;
      csr_wdata = fs;
      @(negedge clock);
      csr_we    = 1'b0;
      csr_wdata = FS_W'($urandom);
   endtask

   // Random sample: mostly uniform, with the range edges and the
   // rounding boundary (511/512) mixed in.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] edges [5] = '{10'd0, 10'd1, 10'd511, 10'd512, 10'd1023};
      if ($urandom_range(0, 99) < 20) begin
         return edges[$urandom_range(0, 4)];
      end
      return SAMPLE_W'($urandom);
   endfunction

   initial begin : stimulus
      logic [SAMPLE_W-1:0] directed [12];
      logic [FS_W-1:0]     fs_plan [9];
      int                  idle_plan [3];

      // At reset full scale is 5000 mV: 1023 reads 4.995, 205 reads 1.001,
      // 21 reads 0.103, 102 reads 0.498; alternating bit patterns as well.
      directed = '{10'd0, 10'd1023, 10'd1, 10'd1022, 10'd512, 10'd511,
                   10'h155, 10'h2aa, 10'd205, 10'd21, 10'd102, 10'd819};

      // Full-scale settings: both range ends, zero (reads 0.000 always),
      // values above 9999 where the reading clamps at 9.999, and random ones.
      fs_plan = '{14'd9999, 14'd1, 14'd0, 14'd16383, 14'd10000, 14'd5000,
                  14'd1024, FS_W'($urandom_range(1, 9999)),
                  FS_W'($urandom_range(0, 16383))};

      // no idling / sender idle 45% / both sides idle 23% (receiver cannot
      // stall, so only the sender side applies)
      idle_plan = '{0, 45, 23};

      // hold reset from time zero, then release it
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // directed transactions against the reset value of full scale
      foreach (directed[i]) begin
         send_sample(directed[i]);
      end
      drain_frames();

      foreach (fs_plan[p]) begin
         write_full_scale(fs_plan[p]);
         idle_pct = idle_plan[p % 3];

         // each setting opens with the sample extremes and mid-scale
         send_sample(10'd0);
         send_sample(10'd512);
         send_sample(10'd1023);

         repeat (37) begin
            send_sample(pick_sample());
            // now and then let the display run dry mid-phase
            if ($urandom_range(0, 29) == 0) begin
               drain_frames();
            end
         end
         drain_frames();
      end

      // leftover check happens in the checker on the next rising edge
      run_done = 1'b1;
      @(negedge clock);
      @(negedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/avsd_pkg.sv
sv/avsd_front.sv
sv/avsd_fifo.sv
sv/avsd_back.sv
sv/adc_voltmeter_seven_segment_frames.sv
verif/voltmeter_frame_checker.sv
verif/tb_top.sv
